/* hdl/ssc_pkg.sv */
package ssc_pkg;

  localparam int NORM_W    = 32;  // normal component width, Q2.30
  localparam int NORM_FRAC = 30;
  localparam int SCALE_SH  = 60;  // pre-scale of squared distance before the root
  localparam int QUOT_W    = 31;  // normal magnitude never exceeds 2^30

endpackage

/* hdl/ssc_dly.sv */
module ssc_dly #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign dout = tap_r[DEPTH-1];

endmodule

/* hdl/ssc_sqr.sv */
module ssc_sqr #(
  parameter int AW = 33
) (
  input  logic            clk,
  input  logic            en,
  input  logic [AW-1:0]   a,
  output logic [2*AW-1:0] sq
);

  localparam int LW = (AW + 1) / 2;
  localparam int HW = AW - LW;

  logic [HW-1:0]      a_hi;
  logic [LW-1:0]      a_lo;
  logic [2*HW-1:0]    hh_r;
  logic [HW+LW-1:0]   hl_r;
  logic [2*LW-1:0]    ll_r;
  logic [2*AW-1:0]    sq_r;

  assign a_hi = a[AW-1:LW];
  assign a_lo = a[LW-1:0];

  // split square into half-width partial products, registered, then combined into the registered square
  always_ff @(posedge clk) begin
    if (en) begin
      hh_r <= a_hi * a_hi;
      hl_r <= a_hi * a_lo;
      ll_r <= a_lo * a_lo;
      sq_r <= ((2*AW)'(hh_r) << (2*LW)) + ((2*AW)'(hl_r) << (LW+1)) + (2*AW)'(ll_r);
    end
  end

  assign sq = sq_r;

endmodule

/* hdl/ssc_isqrt.sv */
module ssc_isqrt #(
  parameter int IN_W = 126
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [IN_W-1:0]          x,
  output logic [(IN_W+1)/2-1:0]    root
);

  localparam int OUT_W = (IN_W + 1) / 2;
  localparam int AW    = IN_W + 2;

  logic [AW-1:0]    rem_r  [OUT_W];
  logic [OUT_W-1:0] root_r [OUT_W];

  // one root bit per stage, most significant first
  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    localparam int B = OUT_W - 1 - k;
    logic [AW-1:0]    rem_in;
    logic [AW-1:0]    trial;
    logic [OUT_W-1:0] root_in;

    if (k == 0) begin : g_first
      assign rem_in  = AW'(x);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    assign trial = (AW'(root_in) << (B + 1)) | (AW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem_r[k]  <= rem_in - trial;
          root_r[k] <= root_in | (OUT_W'(1) << B);
        end else begin
          rem_r[k]  <= rem_in;
          root_r[k] <= root_in;
        end
      end
    end
  end

  assign root = root_r[OUT_W-1];

endmodule

/* hdl/ssc_div.sv */
module ssc_div
  import ssc_pkg::*;
#(
  parameter int NUM_W = 93,
  parameter int DEN_W = 63
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic [QUOT_W-1:0] quot
);

  localparam int AW = (NUM_W > DEN_W + QUOT_W) ? NUM_W : DEN_W + QUOT_W;

  logic [AW-1:0]     rem_r [QUOT_W];
  logic [DEN_W-1:0]  den_r [QUOT_W];
  logic [QUOT_W-1:0] q_r   [QUOT_W];

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    localparam int J = QUOT_W - 1 - k;
    logic [AW-1:0]     rem_in;
    logic [AW-1:0]     trial;
    logic [DEN_W-1:0]  den_in;
    logic [QUOT_W-1:0] q_in;

    if (k == 0) begin : g_first
      assign rem_in = AW'(num);
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign q_in   = q_r[k-1];
    end

    assign trial = AW'(den_in) << J;

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_in;
        if (rem_in >= trial) begin
          rem_r[k] <= rem_in - trial;
          q_r[k]   <= q_in | (QUOT_W'(1) << J);
        end else begin
          rem_r[k] <= rem_in;
          q_r[k]   <= q_in;
        end
      end
    end
  end

  assign quot = q_r[QUOT_W-1];

endmodule

/* hdl/sphere_sphere_contact_core.sv */
// Sphere pair contact test: hit flag, unit normal and contact point.
// Pipeline depth from accepted input word to output word is set by the one-bit-per-stage
//   square root (COORD_WIDTH + 31 stages) followed by the 31-stage normal divider.
// Throughput: one word per cycle; the whole pipeline holds while the output is stalled.
// Reset: synchronous active-low rst_n clears all valid bits; data registers are not reset.
module sphere_sphere_contact_core
  import ssc_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // first_x, first_y, first_z, first_radius, second_x, second_y, second_z, second_radius
  input  logic [((8*COORD_WIDTH-2)+7)/8*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // normal_x, normal_y, normal_z, contact_x, contact_y, contact_z
  output logic [3*NORM_W+3*COORD_WIDTH-1:0] out_tdata,
  // hit
  output logic out_tuser
);

  localparam int W    = COORD_WIDTH;
  localparam int MW   = W + 1;
  localparam int DW   = 2 * W + 2;
  localparam int XW   = DW + SCALE_SH;
  localparam int RW   = (XW + 1) / 2;
  localparam int NUMW = MW + SCALE_SH;
  localparam int RXW  = (W - 1 > NORM_FRAC) ? W - 1 : NORM_FRAC + 1;
  localparam int HIW  = RXW - NORM_FRAC;
  localparam int SR   = 5 + RW;          // stage of the root result
  localparam int SD   = SR + QUOT_W;     // stage of the quotients
  localparam int LAT  = SD + 2;

  logic en;
  logic [LAT-1:0] vld_r;

  assign en         = !out_tvalid || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // unpack input word
  logic [W-1:0]   f_c [3];
  logic [W-1:0]   s_c [3];
  logic [W-2:0]   f_rad, s_rad;

  for (genvar i = 0; i < 3; i++) begin : g_unp
    assign f_c[i] = in_tdata[i*W +: W];
    assign s_c[i] = in_tdata[(4+i)*W - 1 +: W];
  end
  assign f_rad = in_tdata[3*W +: W-1];
  assign s_rad = in_tdata[7*W - 1 +: W-1];

  // stage 1: differences and radius sum
  logic [MW-1:0]  mag_r  [3];
  logic [2:0]     neg_r;
  logic [W-1:0]   base_r [3];
  logic [W-1:0]   rs_r;
  logic [W-2:0]   r2_r;

  for (genvar i = 0; i < 3; i++) begin : g_s1
    logic signed [MW-1:0] d;
    assign d = $signed({f_c[i][W-1], f_c[i]}) - $signed({s_c[i][W-1], s_c[i]});
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i]  <= d[MW-1];
        mag_r[i]  <= d[MW-1] ? MW'(-d) : MW'(d);
        base_r[i] <= s_c[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rs_r <= W'(f_rad) + W'(s_rad);
      r2_r <= s_rad;
    end
  end

  // stages 2-3: squares
  logic [2*MW-1:0] sq [3];
  logic [2*W-1:0]  rsq;

  for (genvar i = 0; i < 3; i++) begin : g_sq
    ssc_sqr #(.AW(MW)) u_sqr (.clk(clk), .en(en), .a(mag_r[i]), .sq(sq[i]));
  end
  ssc_sqr #(.AW(W)) u_rsq (.clk(clk), .en(en), .a(rs_r), .sq(rsq));

  // stage 4: squared distance; stage 5: compare
  logic [DW-1:0]  dsq_r, dsq5_r, rsq_r;
  logic           hit5_r, zero5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dsq_r   <= DW'(sq[0]) + DW'(sq[1]) + DW'(sq[2]);
      rsq_r   <= DW'(rsq);
      dsq5_r  <= dsq_r;
      hit5_r  <= dsq_r < rsq_r;
      zero5_r <= dsq_r == '0;
    end
  end

  // length = floor(sqrt(dsq * 2^60))
  logic [RW-1:0] len;
  ssc_isqrt #(.IN_W(XW)) u_isqrt (
    .clk(clk), .en(en), .x({dsq5_r, SCALE_SH'(0)}), .root(len)
  );

  // carry side data down to where it is needed
  logic [3*MW-1:0]     mag_d;
  logic [W-2:0]        r2_d;
  logic [3+3*W-1:0]    nb_d;
  logic [1:0]          hz_d;

  ssc_dly #(.WIDTH(3*MW), .DEPTH(SR-1)) u_dly_mag (
    .clk(clk), .en(en), .din({mag_r[2], mag_r[1], mag_r[0]}), .dout(mag_d)
  );
  ssc_dly #(.WIDTH(W-1), .DEPTH(SD-1)) u_dly_r2 (
    .clk(clk), .en(en), .din(r2_r), .dout(r2_d)
  );
  ssc_dly #(.WIDTH(3+3*W), .DEPTH(SD)) u_dly_nb (
    .clk(clk), .en(en), .din({neg_r, base_r[2], base_r[1], base_r[0]}), .dout(nb_d)
  );
  ssc_dly #(.WIDTH(2), .DEPTH(SD-4)) u_dly_hz (
    .clk(clk), .en(en), .din({hit5_r, zero5_r}), .dout(hz_d)
  );

  // normal magnitudes, then offsets along the normal
  logic [QUOT_W-1:0]        quot [3];
  logic [RXW-1:0]           r2x;
  logic [QUOT_W-1:0]        q_r    [3];
  logic [QUOT_W+HIW-1:0]    phi_r  [3];
  logic [QUOT_W+NORM_FRAC-1:0] plo_r [3];

  assign r2x = RXW'(r2_d);

  for (genvar i = 0; i < 3; i++) begin : g_lane
    ssc_div #(.NUM_W(NUMW), .DEN_W(RW)) u_div (
      .clk(clk), .en(en), .num({mag_d[i*MW +: MW], SCALE_SH'(0)}), .den(len), .quot(quot[i])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i]   <= quot[i];
        phi_r[i] <= quot[i] * r2x[RXW-1:NORM_FRAC];
        plo_r[i] <= quot[i] * r2x[NORM_FRAC-1:0];
      end
    end
  end

  // final stage: output register
  logic [NORM_W-1:0] nrm_r [3];
  logic [W-1:0]      cnt_r [3];
  logic              hit_r;

  for (genvar i = 0; i < 3; i++) begin : g_out
    logic [W-1:0] off;
    logic [W-1:0] base;
    logic         neg;
    assign off  = W'(phi_r[i]) + W'(plo_r[i] >> NORM_FRAC);
    assign base = nb_d[i*W +: W];
    assign neg  = nb_d[3*W + i];
    always_ff @(posedge clk) begin
      if (en) begin
        priority if (!hz_d[1]) begin
          nrm_r[i] <= '0;
          cnt_r[i] <= '0;
        end else if (hz_d[0]) begin
          nrm_r[i] <= '0;
          cnt_r[i] <= base;
        end else begin
          nrm_r[i] <= neg ? NORM_W'(-NORM_W'(q_r[i])) : NORM_W'(q_r[i]);
          cnt_r[i] <= neg ? base - off : base + off;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= hz_d[1];
    end
  end

  assign out_tdata = {cnt_r[2], cnt_r[1], cnt_r[0], nrm_r[2], nrm_r[1], nrm_r[0]};
  assign out_tuser = hit_r;

endmodule

/* hdl/ssc_checker.sv */
module ssc_checker
  import ssc_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic [((8*COORD_WIDTH-2)+7)/8*8-1:0] in_tdata,
  input logic out_tvalid,
  input logic out_tready,
  input logic [3*NORM_W+3*COORD_WIDTH-1:0] out_tdata,
  input logic out_tuser
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output word changed");

  a_back_press: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss word carries nonzero fields");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind sphere_sphere_contact_core ssc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ssc_checker (.*);
